[src/ebiag_pkg.sv]
// shared types, constants and helpers of the essential-bit injection address generator
`default_nettype none
package ebiag_pkg;

  localparam int LINE_BITS     = 32;
  localparam int LINE_OFFSET_B = 10;

  localparam int LINE_W   = 24;
  localparam int FW_W     = 7;
  localparam int FRAME_W  = 20;
  localparam int BIT_W    = 5;
  localparam int CMD_W    = 40;
  localparam int COUNT_W  = 32;
  localparam int CFG_IDX_W = 2;

  // scanned mask width, never above the 5-bit bit index range
  localparam int SCAN_W = (LINE_BITS > 32) ? 32 : LINE_BITS;

  // quotient bits resolved per divider cycle
  localparam int DIV_RADIX_BITS = 3;
  localparam int DIV_STEPS      = LINE_W / DIV_RADIX_BITS;
  localparam int STEP_W         = $clog2(DIV_STEPS);

  localparam logic [7:0] CMD_PREFIX = 8'hC0;

  localparam logic [CFG_IDX_W-1:0] CFG_FAMILY_SELECT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WORDS_A = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WORDS_B = 2'd2;

  localparam logic [FW_W-1:0] FRAME_WORDS_A_RST = 7'd101;
  localparam logic [FW_W-1:0] FRAME_WORDS_B_RST = 7'd123;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIN,
    ST_EMIT
  } ebiag_state_t;

  typedef struct packed {
    logic [FW_W-1:0]   rem;
    logic [LINE_W-1:0] quo;
  } ebiag_div_t;

  // several restoring division steps; the remainder stays below the divisor
  function automatic ebiag_div_t ebiag_div_step(input ebiag_div_t cur,
                                                input logic [FW_W-1:0] dvs);
    ebiag_div_t  res;
    logic [FW_W:0] t;
    res = cur;
    for (int k = 0; k < DIV_RADIX_BITS; k++) begin
      t = {res.rem, res.quo[LINE_W-1]};
      res.quo = {res.quo[LINE_W-2:0], 1'b0};
      if (t >= {1'b0, dvs}) begin
        t = t - {1'b0, dvs};
        res.quo[0] = 1'b1;
      end
      res.rem = t[FW_W-1:0];
    end
    return res;
  endfunction

  // index of the lowest set bit
  function automatic logic [BIT_W-1:0] ebiag_lowest(input logic [SCAN_W-1:0] m);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = SCAN_W - 1; i >= 0; i--) begin
      if (m[i]) idx = BIT_W'(i);
    end
    return idx;
  endfunction

endpackage
`default_nettype wire

[src/essential_bit_injection_address_gen_core.sv]
// top level: essential-bit mask to fault-injection command generator
// sequence: the idle state accepts a line, the divider state resolves 3 quotient
//   bits per step in the shared compare-subtract unit, the finish state latches
//   the address, then the emit state loads one command per cycle, unless out_ready
//   stalls a full output register; a new line is accepted only in the idle state
// reset: synchronous active low; clears the sequencer, output valid, command
//   count and loads the register defaults (mode A, 101 and 123 words per frame)
`default_nettype none
module essential_bit_injection_address_gen_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // item in
  input  wire logic                           in_valid,
  output      logic                           in_ready,
  input  wire logic [ebiag_pkg::LINE_W-1:0]   in_line_number,
  input  wire logic [31:0]                    in_line_mask,
  // commands out
  output      logic                           out_valid,
  input  wire logic                           out_ready,
  output      logic [ebiag_pkg::CMD_W-1:0]    out_inject_command,
  output      logic [ebiag_pkg::FRAME_W-1:0]  out_frame_address,
  output      logic [ebiag_pkg::FW_W-1:0]     out_word_in_frame,
  output      logic [ebiag_pkg::BIT_W-1:0]    out_bit_in_word,
  output      logic                           out_address_invalid,
  output      logic [ebiag_pkg::COUNT_W-1:0]  out_emitted_total,
  output      logic                           out_last_of_line,
  // configuration writes
  input  wire logic                           cfg_valid,
  output      logic                           cfg_ready,
  input  wire logic [ebiag_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ebiag_pkg::FW_W-1:0]     cfg_data
);
  import ebiag_pkg::*;

  // configuration registers
  logic            family_r;
  logic [FW_W-1:0] fw_a_r;
  logic [FW_W-1:0] fw_b_r;

  // sequencer
  ebiag_state_t state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  // divider working registers, quo starts as the dividend
  ebiag_div_t      div_r, div_nxt;
  ebiag_div_t      div_step;
  logic [FW_W-1:0] dvs_r, dvs_nxt;
  logic            below_r, below_nxt;

  // per-line address, latched after the divide
  logic [FRAME_W-1:0] frame_r, frame_nxt;
  logic [FW_W-1:0]    word_r, word_nxt;
  logic               inval_r, inval_nxt;
  logic [SCAN_W-1:0]  mask_r, mask_nxt;
  logic [SCAN_W-1:0]  mask_rest;

  logic [COUNT_W-1:0] count_r, count_nxt;

  // output register
  logic               ov_r, ov_nxt;
  logic [FRAME_W-1:0] o_frame_r, o_frame_nxt;
  logic [FW_W-1:0]    o_word_r, o_word_nxt;
  logic [BIT_W-1:0]   o_bit_r, o_bit_nxt;
  logic               o_inval_r, o_inval_nxt;
  logic [COUNT_W-1:0] o_total_r, o_total_nxt;
  logic               o_last_r, o_last_nxt;

  logic [LINE_W-1:0]  line_red;
  logic [FW_W-1:0]    fw_sel;

  // configuration port never stalls
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      family_r <= 1'b0;
      fw_a_r   <= FRAME_WORDS_A_RST;
      fw_b_r   <= FRAME_WORDS_B_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_FAMILY_SELECT: family_r <= cfg_data[0];
        CFG_FRAME_WORDS_A: fw_a_r   <= cfg_data;
        CFG_FRAME_WORDS_B: fw_b_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // mode B removes the line offset first; zero words per frame counts as one
  assign line_red = in_line_number - LINE_W'(LINE_OFFSET_B);
  always_comb begin
    if (family_r) fw_sel = fw_b_r;
    else          fw_sel = fw_a_r;
    if (fw_sel == '0) fw_sel = FW_W'(1);
  end

  // the one shared compare-subtract unit
  assign div_step  = ebiag_div_step(div_r, dvs_r);
  // mask with its lowest set bit removed
  assign mask_rest = mask_r & (mask_r - SCAN_W'(1));

  always_comb begin
    state_nxt   = state_r;
    step_nxt    = step_r;
    div_nxt     = div_r;
    dvs_nxt     = dvs_r;
    below_nxt   = below_r;
    frame_nxt   = frame_r;
    word_nxt    = word_r;
    inval_nxt   = inval_r;
    mask_nxt    = mask_r;
    count_nxt   = count_r;
    ov_nxt      = ov_r;
    o_frame_nxt = o_frame_r;
    o_word_nxt  = o_word_r;
    o_bit_nxt   = o_bit_r;
    o_inval_nxt = o_inval_r;
    o_total_nxt = o_total_r;
    o_last_nxt  = o_last_r;
    in_ready    = 1'b0;

    // a taken command leaves the output register empty
    if (ov_r && out_ready) ov_nxt = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          dvs_nxt  = fw_sel;
          mask_nxt = in_line_mask[SCAN_W-1:0];
          step_nxt = '0;
          div_nxt.rem = '0;
          if (family_r) begin
            div_nxt.quo = line_red;
            below_nxt   = (in_line_number < LINE_W'(LINE_OFFSET_B));
          end else begin
            div_nxt.quo = in_line_number;
            below_nxt   = 1'b0;
          end
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        div_nxt  = div_step;
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(DIV_STEPS - 1)) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        // quotient zero or a line below the offset gives a negative frame
        if (below_r) begin
          frame_nxt = '1;
          word_nxt  = '0;
          inval_nxt = 1'b1;
        end else begin
          frame_nxt = FRAME_W'(div_r.quo - LINE_W'(1));
          word_nxt  = div_r.rem;
          inval_nxt = (div_r.quo == '0);
        end
        if (mask_r == '0) state_nxt = ST_IDLE;
        else              state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!ov_r || out_ready) begin
          ov_nxt      = 1'b1;
          o_frame_nxt = frame_r;
          o_word_nxt  = word_r;
          o_inval_nxt = inval_r;
          o_bit_nxt   = ebiag_lowest(mask_r);
          o_last_nxt  = (mask_rest == '0);
          count_nxt   = count_r + COUNT_W'(1);
          o_total_nxt = count_r + COUNT_W'(1);
          mask_nxt    = mask_rest;
          if (mask_rest == '0) state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      count_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    div_r     <= div_nxt;
    dvs_r     <= dvs_nxt;
    below_r   <= below_nxt;
    frame_r   <= frame_nxt;
    word_r    <= word_nxt;
    inval_r   <= inval_nxt;
    mask_r    <= mask_nxt;
    o_frame_r <= o_frame_nxt;
    o_word_r  <= o_word_nxt;
    o_bit_r   <= o_bit_nxt;
    o_inval_r <= o_inval_nxt;
    o_total_r <= o_total_nxt;
    o_last_r  <= o_last_nxt;
  end

  assign out_valid           = ov_r;
  assign out_inject_command  = {CMD_PREFIX, o_frame_r, o_word_r, o_bit_r};
  assign out_frame_address   = o_frame_r;
  assign out_word_in_frame   = o_word_r;
  assign out_bit_in_word     = o_bit_r;
  assign out_address_invalid = o_inval_r;
  assign out_emitted_total   = o_total_r;
  assign out_last_of_line    = o_last_r;

endmodule
`default_nettype wire

[src/ebiag_checker.sv]
// port-level checker for the injection address generator, bound to the top level
`default_nettype none
module ebiag_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [39:0] out_inject_command,
  input wire logic [19:0] out_frame_address,
  input wire logic [6:0]  out_word_in_frame,
  input wire logic [4:0]  out_bit_in_word,
  input wire logic [31:0] out_emitted_total,
  input wire logic        out_last_of_line
);

  // a new line is never taken straight after one was accepted
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while previous line in progress");

  // command word agrees with its separate fields
  a_cmd_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_inject_command[39:32] == 8'hC0 &&
                  out_inject_command[31:12] == out_frame_address &&
                  out_inject_command[11:5] == out_word_in_frame &&
                  out_inject_command[4:0] == out_bit_in_word)
    else $error("command word does not match fields");

  // mid-line commands come while no new line is taken
  a_midline_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_of_line |-> !in_ready)
    else $error("input ready in the middle of a line");

  // stalled command holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_inject_command) &&
                               $stable(out_emitted_total))
    else $error("stalled command changed");

endmodule

bind essential_bit_injection_address_gen_core ebiag_checker u_ebiag_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_inject_command (out_inject_command),
  .out_frame_address  (out_frame_address),
  .out_word_in_frame  (out_word_in_frame),
  .out_bit_in_word    (out_bit_in_word),
  .out_emitted_total  (out_emitted_total),
  .out_last_of_line   (out_last_of_line)
);
`default_nettype wire
